// ===== rtl/core/gnz_pkg.sv =====
// Shared types and constants of the gradient noise block.
package gnz_pkg;

    localparam int COORD_W  = 32;
    localparam int GRAD_W   = 16;
    localparam int OUT_W    = 20;
    localparam int OUT_FRAC = 16;
    localparam int SIDE_W   = 7;
    localparam int ADDR_W   = 13;
    localparam int FRAC_MAX = 24;
    localparam int IDX_W    = 12;

    localparam logic [SIDE_W-1:0] SIDE_MIN = 7'd2;
    localparam logic [SIDE_W-1:0] SIDE_MAX = 7'd64;

    localparam logic KIND_SAMPLE      = 1'b1;
    localparam logic REG_LATTICE_SIDE = 1'b0;
    localparam logic REG_EASE_MODE    = 1'b1;
    localparam logic EASE_SMOOTH      = 1'b1;

    // One classified job between the front and back parts
    typedef struct packed {
        logic                          is_sample;
        logic [3:0]                    in_range;
        logic [3:0][ADDR_W-1:0]        addr;
        logic [2*GRAD_W-1:0]           grad;
        logic [FRAC_MAX-1:0]           frac_x;
        logic [FRAC_MAX-1:0]           frac_y;
    } t_job;

endpackage

// ===== rtl/core/gnz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gnz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write first port, read second port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/gnz_fifo.sv =====
// Small register FIFO with occupancy count.
module gnz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_data[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/core/gnz_front.sv =====
// Front part: accepts items, reduces cell indices and forms table addresses.
module gnz_front #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int FRAC_BITS     = 16,
    parameter int MID_DEPTH     = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_kind,
    input  logic [gnz_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [gnz_pkg::GRAD_W-1:0]   i_grad_x,
    input  logic signed [gnz_pkg::GRAD_W-1:0]   i_grad_y,
    input  logic [gnz_pkg::COORD_W-1:0]         i_coord_x,
    input  logic [gnz_pkg::COORD_W-1:0]         i_coord_y,
    input  logic [gnz_pkg::SIDE_W-1:0]          i_lattice_side,
    input  logic [$clog2(MID_DEPTH+1)-1:0]      i_mid_count,
    output logic                                o_job_valid,
    output gnz_pkg::t_job                       o_job
);

    localparam int F   = FRAC_BITS;
    localparam int IB  = gnz_pkg::COORD_W - F;
    localparam int LCW = $clog2(IB + 2);
    localparam int AW  = gnz_pkg::ADDR_W;

    typedef struct packed {
        logic                            kind;
        logic [gnz_pkg::IDX_W-1:0]       idx;
        logic [2*gnz_pkg::GRAD_W-1:0]    grad;
        logic [F-1:0]                    fx;
        logic [F-1:0]                    fy;
        logic [IB-1:0]                   ix;
        logic [IB-1:0]                   iy;
        logic [5:0]                      rx;
        logic [5:0]                      ry;
    } t_stage;

    t_stage                     r_st [IB+1];
    t_stage                     n_st [IB];
    logic [IB:0]                r_vld;
    logic [LCW-1:0]             r_cnt;
    logic                       accept;
    logic [gnz_pkg::SIDE_W-1:0] side_c;
    logic [5:0]                 div;
    logic [AW-1:0]              base;
    logic [3:0][AW-1:0]         corner;

    // One restoring remainder step: shift in one bit, subtract when it fits
    function automatic logic [5:0] mod_step(logic [5:0] r, logic b, logic [5:0] d);
        logic [6:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[5:0];
    endfunction

    assign accept = i_push && !o_full;
    assign o_full = (32'(r_cnt) + 32'(i_mid_count)) >= 32'(MID_DEPTH);

    // Clamp the side and derive the cell divisor
    always_comb begin
        priority if (i_lattice_side < gnz_pkg::SIDE_MIN) begin
            side_c = gnz_pkg::SIDE_MIN;
        end else if (i_lattice_side > gnz_pkg::SIDE_MAX) begin
            side_c = gnz_pkg::SIDE_MAX;
        end else begin
            side_c = i_lattice_side;
        end
        div = 6'(side_c - 7'd1);
    end

    // Track valid stages and items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            r_vld <= {r_vld[IB-1:0], accept};
            r_cnt <= r_cnt + LCW'(accept) - LCW'(r_vld[IB]);
        end
    end

    // Work out one remainder bit per stage on each axis
    always_comb begin
        for (int k = 0; k < IB; k++) begin
            n_st[k]    = r_st[k];
            n_st[k].rx = mod_step(r_st[k].rx, r_st[k].ix[IB-1-k], div);
            n_st[k].ry = mod_step(r_st[k].ry, r_st[k].iy[IB-1-k], div);
        end
    end

    // Capture the item and advance the stages
    always_ff @(posedge i_clk) begin
        r_st[0] <= '{kind: i_kind, idx: i_entry_index, grad: {i_grad_y, i_grad_x},
                     fx: i_coord_x[F-1:0], fy: i_coord_y[F-1:0],
                     ix: i_coord_x[gnz_pkg::COORD_W-1:F], iy: i_coord_y[gnz_pkg::COORD_W-1:F],
                     rx: '0, ry: '0};
        for (int k = 0; k < IB; k++) begin
            r_st[k+1] <= n_st[k];
        end
    end

    // Form the four corner addresses
    always_comb begin
        base      = AW'(AW'(r_st[IB].ry) * AW'(side_c)) + AW'(r_st[IB].rx);
        corner[0] = base;
        corner[1] = base + AW'(1);
        corner[2] = base + AW'(side_c);
        corner[3] = base + AW'(side_c) + AW'(1);
    end

    // Build the job for the back part
    always_comb begin
        o_job.is_sample = (r_st[IB].kind == gnz_pkg::KIND_SAMPLE);
        o_job.grad      = r_st[IB].grad;
        o_job.frac_x    = gnz_pkg::FRAC_MAX'(r_st[IB].fx);
        o_job.frac_y    = gnz_pkg::FRAC_MAX'(r_st[IB].fy);
        if (o_job.is_sample) begin
            for (int c = 0; c < 4; c++) begin
                o_job.addr[c]     = corner[c];
                o_job.in_range[c] = 32'(corner[c]) < 32'(TABLE_ENTRIES);
            end
        end else begin
            for (int c = 0; c < 4; c++) begin
                o_job.addr[c]     = AW'(r_st[IB].idx);
                o_job.in_range[c] = 32'(r_st[IB].idx) < 32'(TABLE_ENTRIES);
            end
        end
    end

    assign o_job_valid = r_vld[IB];

endmodule

// ===== rtl/core/gnz_back.sv =====
// Back part: table access, corner dot products, easing, bilinear mix and saturation.
module gnz_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int FRAC_BITS     = 16,
    parameter int OUT_DEPTH     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  gnz_pkg::t_job                      i_job,
    output logic                               o_job_pop,
    input  logic                               i_ease_mode,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     i_out_count,
    output logic                               o_res_valid,
    output logic signed [gnz_pkg::OUT_W-1:0]   o_res_value
);

    localparam int F    = FRAC_BITS;
    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int PW   = F + 18;
    localparam int DW   = F + 3;
    localparam int MW   = DW + F + 3;
    localparam int SW   = DW + gnz_pkg::OUT_FRAC + 2;
    localparam int LAT  = 5;
    localparam int BCW  = $clog2(LAT + 1);
    localparam int SH_R = (F > gnz_pkg::OUT_FRAC) ? F - gnz_pkg::OUT_FRAC : 0;
    localparam int SH_L = (F > gnz_pkg::OUT_FRAC) ? 0 : gnz_pkg::OUT_FRAC - F;
    localparam logic [F:0]   ONE       = (F+1)'(1) << F;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
    localparam logic [F+4:0] TEN_ONE   = (F+5)'(10) << F;
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (gnz_pkg::OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (gnz_pkg::OUT_W - 1));

    logic [LAT:1]   r_v;
    logic [BCW-1:0] r_cnt;
    logic           wr_en;
    logic [31:0]    rd_data [4];

    // Stage 1 registers
    logic           r1_sample;
    logic [3:0]     r1_inr;
    logic [F-1:0]   r1_t  [2];
    logic [F-1:0]   r1_sq [2];
    logic [F+4:0]   r1_p  [2];
    // Stage 2 registers
    logic           r2_sample;
    logic signed [PW-1:0] r2_px [4];
    logic signed [PW-1:0] r2_py [4];
    logic [F:0]     r2_sm [2];
    logic [F-1:0]   r2_t3 [2];
    logic [F+4:0]   r2_p  [2];
    // Stage 3 registers
    logic           r3_sample;
    logic signed [DW-1:0] r3_dot [4];
    logic [F:0]     r3_w [2];
    // Stage 4 registers
    logic           r4_sample;
    logic signed [DW-1:0] r4_mx [2];
    logic [F:0]     r4_wy;
    // Stage 5 registers
    logic           r5_sample;
    logic signed [gnz_pkg::OUT_W-1:0] r5_val;

    logic [F-1:0]   e0_t   [2];
    logic [2*F-1:0] e0_tt  [2];
    logic [2*F+2:0] e0_six [2];
    logic [F+4:0]   e0_p   [2];
    logic [31:0]    s1_g   [4];
    logic [F:0]     s1_ox  [4];
    logic [F:0]     s1_oy  [4];
    logic signed [PW-1:0] s1_px [4];
    logic signed [PW-1:0] s1_py [4];
    logic [F:0]     s1_sm [2];
    logic [F-1:0]   s1_t3 [2];
    logic signed [PW:0]   s2_sum [4];
    logic signed [DW-1:0] s2_dot [4];
    logic [F:0]     s2_fade [2];
    logic [F:0]     s2_w    [2];
    logic signed [DW-1:0] s3_mx [2];
    logic signed [DW-1:0] s4_mix;
    logic signed [SW-1:0] s4_sc;
    logic signed [gnz_pkg::OUT_W-1:0] s4_val;

    // Linear blend floor((a*(one-w) + b*w) / one)
    function automatic logic signed [DW-1:0] lerp(logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b,
                                                  logic [F:0] w);
        logic signed [MW-1:0] m;
        m = MW'(a) * MW'(signed'({1'b0, ONE - w})) + MW'(b) * MW'(signed'({1'b0, w}));
        return DW'(m >>> F);
    endfunction

    assign o_job_pop = i_job_valid && ((32'(r_cnt) + 32'(i_out_count)) < 32'(OUT_DEPTH));
    assign wr_en     = o_job_pop && !i_job.is_sample && i_job.in_range[0];

    // One table copy per corner, all written together
    for (genvar c = 0; c < 4; c++) begin : g_bank
        gnz_ram #(
            .WIDTH(32),
            .DEPTH(TABLE_ENTRIES)
        ) u_ram (
            .i_clk    (i_clk),
            .i_wr_en  (wr_en),
            .i_wr_addr(AW'(i_job.addr[0])),
            .i_wr_data(i_job.grad),
            .i_rd_addr(AW'(i_job.addr[c])),
            .o_rd_data(rd_data[c])
        );
    end

    // Track valid stages and items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_cnt <= '0;
        end else begin
            r_v   <= {r_v[LAT-1:1], o_job_pop};
            r_cnt <= r_cnt + BCW'(o_job_pop) - BCW'(r_v[LAT]);
        end
    end

    // Ease, first step: square and fade polynomial
    always_comb begin
        e0_t[0] = i_job.frac_x[F-1:0];
        e0_t[1] = i_job.frac_y[F-1:0];
        for (int a = 0; a < 2; a++) begin
            e0_tt[a]  = (2*F)'(e0_t[a]) * (2*F)'(e0_t[a]);
            e0_six[a] = (2*F+3)'(e0_tt[a]) * (2*F+3)'(6);
            e0_p[a]   = (F+5)'(e0_six[a] >> F) + TEN_ONE - (F+5)'(e0_t[a]) * (F+5)'(15);
        end
    end

    // Corner products and second ease step
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s1_g[c]  = r1_inr[c] ? rd_data[c] : '0;
            s1_ox[c] = ((c & 1) != 0) ? ONE - (F+1)'(r1_t[0]) : (F+1)'(r1_t[0]);
            s1_oy[c] = ((c & 2) != 0) ? ONE - (F+1)'(r1_t[1]) : (F+1)'(r1_t[1]);
            s1_px[c] = PW'(signed'(s1_g[c][15:0])) * PW'(signed'({1'b0, s1_ox[c]}));
            s1_py[c] = PW'(signed'(s1_g[c][31:16])) * PW'(signed'({1'b0, s1_oy[c]}));
        end
        for (int a = 0; a < 2; a++) begin
            s1_sm[a] = (F+1)'(((2*F+2)'(r1_sq[a]) *
                       ((2*F+2)'(THREE_ONE) - ((2*F+2)'(r1_t[a]) << 1))) >> F);
            s1_t3[a] = F'(((2*F)'(r1_sq[a]) * (2*F)'(r1_t[a])) >> F);
        end
    end

    // Dot products and final ease step
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s2_sum[c] = (PW+1)'(r2_px[c]) + (PW+1)'(r2_py[c]);
            s2_dot[c] = DW'(s2_sum[c] >>> 15);
        end
        for (int a = 0; a < 2; a++) begin
            s2_fade[a] = (F+1)'(((2*F+5)'(r2_t3[a]) * (2*F+5)'(r2_p[a])) >> F);
            s2_w[a]    = (i_ease_mode == gnz_pkg::EASE_SMOOTH) ? r2_sm[a] : s2_fade[a];
        end
    end

    // Blend along x
    always_comb begin
        s3_mx[0] = lerp(r3_dot[0], r3_dot[1], r3_w[0]);
        s3_mx[1] = lerp(r3_dot[2], r3_dot[3], r3_w[0]);
    end

    // Blend along y, double, rescale and saturate
    always_comb begin
        s4_mix = lerp(r4_mx[0], r4_mx[1], r4_wy);
        s4_sc  = ((SW'(s4_mix) <<< 1) >>> SH_R) <<< SH_L;
        priority if (s4_sc > SAT_HI) begin
            s4_val = gnz_pkg::OUT_W'(SAT_HI);
        end else if (s4_sc < SAT_LO) begin
            s4_val = gnz_pkg::OUT_W'(SAT_LO);
        end else begin
            s4_val = gnz_pkg::OUT_W'(s4_sc);
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r1_sample <= i_job.is_sample;
        r1_inr    <= i_job.in_range;
        for (int a = 0; a < 2; a++) begin
            r1_t[a]  <= e0_t[a];
            r1_sq[a] <= e0_tt[a][2*F-1:F];
            r1_p[a]  <= e0_p[a];
            r2_sm[a] <= s1_sm[a];
            r2_t3[a] <= s1_t3[a];
            r2_p[a]  <= r1_p[a];
            r3_w[a]  <= s2_w[a];
            r4_mx[a] <= s3_mx[a];
        end
        for (int c = 0; c < 4; c++) begin
            r2_px[c]  <= s1_px[c];
            r2_py[c]  <= s1_py[c];
            r3_dot[c] <= s2_dot[c];
        end
        r2_sample <= r1_sample;
        r3_sample <= r2_sample;
        r4_sample <= r3_sample;
        r4_wy     <= r3_w[1];
        r5_sample <= r4_sample;
        r5_val    <= s4_val;
    end

    assign o_res_valid = r_v[LAT] && r5_sample;
    assign o_res_value = r5_val;

endmodule

// ===== rtl/core/gradient_noise_2d.sv =====
// Top level of the 2D gradient noise unit.
//
// Input channel (push/full): each transfer carries one item. A write item (kind 0)
// stores grad_x/grad_y at entry_index of the gradient table; a sample item (kind 1)
// evaluates noise at the unsigned coordinate and yields one noise_value.
// Result channel (empty/pop): the oldest result is shown while empty is low and
// leaves on a transfer with pop high.
// Configuration: i_cfg_wr_en writes register i_cfg_index (0 lattice side,
// 1 ease mode) from i_cfg_wdata; write only while no item is in flight.
// Throughput: one item per cycle while full is low. On its way to the result an
// item passes an input register, one remainder stage per integer coordinate bit,
// the job queue, five back stages and the result queue.
// The four corner reads use four copies of the gradient table, so all four
// corners are read in the same cycle.
// Reset clears both queues and the pipelines and restores lattice side 64 and the
// quintic fade; the table contents stay undefined until written.
// When the receiver stalls, results collect in an eight-entry queue, then the
// back part and the job queue fill and full rises; nothing is lost.
module gradient_noise_2d #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int FRAC_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_kind,
    input  logic [gnz_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [gnz_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnz_pkg::GRAD_W-1:0] i_grad_y,
    input  logic [gnz_pkg::COORD_W-1:0]       i_coord_x,
    input  logic [gnz_pkg::COORD_W-1:0]       i_coord_y,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [gnz_pkg::OUT_W-1:0]  o_noise_value,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_index,
    input  logic [gnz_pkg::SIDE_W-1:0]        i_cfg_wdata
);

    localparam int MID_DEPTH = 32;
    localparam int OUT_DEPTH = 8;
    localparam int JOB_W     = $bits(gnz_pkg::t_job);

    logic [gnz_pkg::SIDE_W-1:0]       r_lattice_side;
    logic                             r_ease_mode;
    logic                             job_push;
    gnz_pkg::t_job                    job_in;
    gnz_pkg::t_job                    job_head;
    logic                             mid_empty;
    logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;
    logic                             job_pop;
    logic                             res_valid;
    logic signed [gnz_pkg::OUT_W-1:0] res_value;
    logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice_side <= gnz_pkg::SIDE_MAX;
            r_ease_mode    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gnz_pkg::REG_LATTICE_SIDE: r_lattice_side <= i_cfg_wdata;
                gnz_pkg::REG_EASE_MODE:    r_ease_mode    <= i_cfg_wdata[0];
                default:                   r_ease_mode    <= r_ease_mode;
            endcase
        end
    end

    gnz_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .FRAC_BITS    (FRAC_BITS),
        .MID_DEPTH    (MID_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_lattice_side(r_lattice_side),
        .i_mid_count   (mid_count),
        .o_job_valid   (job_push),
        .o_job         (job_in)
    );

    gnz_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(MID_DEPTH)
    ) u_mid_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_wdata(job_in),
        .i_pop  (job_pop),
        .o_rdata(job_head),
        .o_empty(mid_empty),
        .o_count(mid_count)
    );

    gnz_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .FRAC_BITS    (FRAC_BITS),
        .OUT_DEPTH    (OUT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!mid_empty),
        .i_job      (job_head),
        .o_job_pop  (job_pop),
        .i_ease_mode(r_ease_mode),
        .i_out_count(out_count),
        .o_res_valid(res_valid),
        .o_res_value(res_value)
    );

    gnz_fifo #(
        .WIDTH(gnz_pkg::OUT_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_wdata(res_value),
        .i_pop  (pop),
        .o_rdata(o_noise_value),
        .o_empty(empty),
        .o_count(out_count)
    );

`ifndef NO_ASSERTIONS
    // Credit on the job queue must prevent overflow
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> (32'(mid_count) < 32'(MID_DEPTH) || job_pop))
        else $error("job queue overflow");

    // Credit on the result queue must prevent overflow
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (32'(out_count) < 32'(OUT_DEPTH) || (pop && !empty)))
        else $error("result queue overflow");

    // The back part only takes jobs that exist
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !mid_empty)
        else $error("job taken from empty queue");

    // No result is pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

// ===== tb/sv/gradient_noise_2d_tb.sv =====
// Self-checking testbench for the 2D gradient noise unit.
`timescale 1ns / 1ps
module gradient_noise_2d_tb;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic EASE_FADE   = 1'b0;
    localparam int   ENTRIES     = 4096;
    localparam int   FRAC        = 16;
    localparam longint ONE       = 64'sd1 << FRAC;
    localparam int   QUIET_LIMIT = 5000;
    localparam int   HOLD_LEN    = 400;
    localparam int   DRAIN_WAIT  = 40;

    typedef struct packed {
        logic                              kind;
        logic [gnz_pkg::IDX_W-1:0]         idx;
        logic signed [gnz_pkg::GRAD_W-1:0] gx;
        logic signed [gnz_pkg::GRAD_W-1:0] gy;
        logic [gnz_pkg::COORD_W-1:0]       cx;
        logic [gnz_pkg::COORD_W-1:0]       cy;
    } t_noise_item;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [gnz_pkg::OUT_W-1:0] o_noise_value;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_index = gnz_pkg::REG_LATTICE_SIDE;
    logic [gnz_pkg::SIDE_W-1:0] i_cfg_wdata = '0;
    t_noise_item held = '0;

    // Stimulus, gradient copy and expected noise values
    t_noise_item pending[$];
    logic signed [gnz_pkg::OUT_W-1:0] noise_expected[$];
    logic signed [gnz_pkg::GRAD_W-1:0] lat_gx[ENTRIES];
    logic signed [gnz_pkg::GRAD_W-1:0] lat_gy[ENTRIES];
    bit loaded[ENTRIES];
    int cfg_side = 64;
    logic cfg_ease = EASE_FADE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done;
    int hold_left;
    int quiet;
    int n_writes = 0, n_samples = 0, n_checked = 0, n_errors = 0;
    logic signed [gnz_pkg::OUT_W-1:0] want;

    gradient_noise_2d u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (held.kind),
        .i_entry_index (held.idx),
        .i_grad_x      (held.gx),
        .i_grad_y      (held.gy),
        .i_coord_x     (held.cx),
        .i_coord_y     (held.cy),
        .empty         (empty),
        .pop           (pop),
        .o_noise_value (o_noise_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_side();
        if (cfg_side < 2) return 2;
        if (cfg_side > 64) return 64;
        return cfg_side;
    endfunction

    function automatic longint ease_weight(longint t);
        longint sq, t3, p;
        sq = (t * t) >>> FRAC;
        if (cfg_ease == gnz_pkg::EASE_SMOOTH) return (sq * (3 * ONE - 2 * t)) >>> FRAC;
        t3 = (sq * t) >>> FRAC;
        p = ((6 * t * t) >>> FRAC) + 10 * ONE - 15 * t;
        return (t3 * p) >>> FRAC;
    endfunction

    function automatic longint corner_dot(int e, longint ox, longint oy);
        longint gx, gy;
        if (e >= ENTRIES) return 0;
        gx = longint'(lat_gx[e]);
        gy = longint'(lat_gy[e]);
        return (gx * ox + gy * oy) >>> 15;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return (a * (ONE - w) + b * w) >>> FRAC;
    endfunction

    // Noise value expected at one coordinate with the current table and settings
    function automatic logic signed [gnz_pkg::OUT_W-1:0] noise_at(logic [31:0] x,
                                                                  logic [31:0] y);
        int s, base;
        longint fx, fy, wx, wy, d0, d1, d2, d3, r;
        s = eff_side();
        fx = longint'(x[15:0]);
        fy = longint'(y[15:0]);
        base = (int'(y[31:16]) % (s - 1)) * s + int'(x[31:16]) % (s - 1);
        d0 = corner_dot(base, fx, fy);
        d1 = corner_dot(base + 1, ONE - fx, fy);
        d2 = corner_dot(base + s, fx, ONE - fy);
        d3 = corner_dot(base + s + 1, ONE - fx, ONE - fy);
        wx = ease_weight(fx);
        wy = ease_weight(fy);
        r = blend(blend(d0, d1, wx), blend(d2, d3, wx), wy) * 2;
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r[gnz_pkg::OUT_W-1:0];
    endfunction

    task automatic queue_write(int idx, logic [15:0] gx, logic [15:0] gy);
        t_noise_item it;
        it = '0;
        it.kind = KIND_WRITE;
        it.idx = gnz_pkg::IDX_W'(idx);
        it.gx = gx;
        it.gy = gy;
        it.cx = $urandom();
        it.cy = $urandom();
        pending.push_back(it);
        loaded[idx] = 1'b1;
    endtask

    // Load any corner not yet written, then queue the sample itself
    task automatic queue_sample(logic [31:0] x, logic [31:0] y);
        t_noise_item it;
        int s, base;
        int corner[4];
        s = eff_side();
        base = (int'(y[31:16]) % (s - 1)) * s + int'(x[31:16]) % (s - 1);
        corner = '{base, base + 1, base + s, base + s + 1};
        foreach (corner[k])
            if (!loaded[corner[k]]) queue_write(corner[k], 16'($urandom()), 16'($urandom()));
        it = '0;
        it.kind = gnz_pkg::KIND_SAMPLE;
        it.idx = gnz_pkg::IDX_W'($urandom());
        it.gx = gnz_pkg::GRAD_W'($urandom());
        it.gy = gnz_pkg::GRAD_W'($urandom());
        it.cx = x;
        it.cy = y;
        pending.push_back(it);
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] c;
        c = $urandom();
        case ($urandom_range(5))
            0: c[15:0] = 16'h0000;
            1: c[15:0] = 16'hFFFF;
            2: c[15:0] = 16'h8000;
            default: ;
        endcase
        return c;
    endfunction

    task automatic set_reg(logic index, int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= gnz_pkg::SIDE_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (index == gnz_pkg::REG_LATTICE_SIDE) cfg_side = value;
        else cfg_ease = value[0];
    endtask

    // Hold until every item is taken and every result has arrived
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || push || noise_expected.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic run_phase(int side, logic ease, int sidle, int ridle, int count,
                             bit long_hold);
        set_reg(gnz_pkg::REG_LATTICE_SIDE, side);
        set_reg(gnz_pkg::REG_EASE_MODE, ease);
        @(posedge i_clk);
        send_idle_pct <= sidle;
        recv_stall_pct <= ridle;
        if (long_hold) hold_req <= 1'b1;
        @(negedge i_clk);
        repeat (count) begin
            if ($urandom_range(9) < 3)
                queue_write($urandom_range(ENTRIES - 1), 16'($urandom()), 16'($urandom()));
            else
                queue_sample(rand_coord(), rand_coord());
        end
        wait_drained();
    endtask

    // Driver: offer pending items, apply each accepted transfer to the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                if (held.kind == gnz_pkg::KIND_SAMPLE) begin
                    noise_expected.push_back(noise_at(held.cx, held.cy));
                    n_samples++;
                end else begin
                    lat_gx[held.idx] = held.gx;
                    lat_gy[held.idx] = held.gy;
                    n_writes++;
                end
            end
            if (!push || !full) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held <= pending.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, stall at random, hold off once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (noise_expected.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_noise_value);
                end else begin
                    want = noise_expected.pop_front();
                    n_checked++;
                    if (o_noise_value !== want) begin
                        n_errors++;
                        $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                                 $time, want, o_noise_value);
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: gradient extremes on the first cell, fraction and cell extremes
        @(negedge i_clk);
        queue_write(0, 16'h7FFF, 16'h7FFF);
        queue_write(1, 16'h8000, 16'h8000);
        queue_write(64, 16'h8000, 16'h7FFF);
        queue_write(65, 16'h7FFF, 16'h8000);
        queue_write(4095, 16'hFFFF, 16'h0000);
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'h0000_FFFF, 32'h0000_FFFF);
        queue_sample(32'h0000_8000, 32'h0000_FFFF);
        queue_sample(32'h0000_FFFF, 32'h0000_0000);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_sample(32'h003E_FFFF, 32'h003E_0000);
        queue_sample(32'h003F_0000, 32'h007E_8000);
        queue_sample(32'hFFFF_0000, 32'h0000_FFFF);
        wait_drained();

        run_phase(64, EASE_FADE, 0, 0, 120, 1'b0);
        run_phase(2, gnz_pkg::EASE_SMOOTH, 50, 0, 120, 1'b0);
        run_phase(127, EASE_FADE, 0, 50, 120, 1'b1);
        run_phase(0, gnz_pkg::EASE_SMOOTH, 37, 37, 120, 1'b0);
        run_phase(3, EASE_FADE, 0, 0, 110, 1'b0);
        run_phase(1, gnz_pkg::EASE_SMOOTH, 50, 50, 100, 1'b0);
        run_phase($urandom_range(4, 63), 1'($urandom_range(1)), 37, 37, 110, 1'b0);

        $display("Covered %0d gradient writes and %0d samples over seven side/ease settings,",
                 n_writes, n_samples);
        $display("with sender gaps, receiver stalls and one long hold-off; %0d results checked.",
                 n_checked);
        if (n_errors == 0 && noise_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== gradient_noise_2d.f =====
rtl/core/gnz_pkg.sv
rtl/core/gnz_ram.sv
rtl/core/gnz_fifo.sv
rtl/core/gnz_front.sv
rtl/core/gnz_back.sv
rtl/core/gradient_noise_2d.sv
tb/sv/gradient_noise_2d_tb.sv
